>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`BDQ_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/bdq_pkg.sv
package bdq_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} st_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
	} cell_ctrl_t;

endpackage

>>> rtl/core/bdq_req_if.sv
interface bdq_req_if import bdq_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

>>> rtl/core/bdq_rsp_if.sv
interface bdq_rsp_if import bdq_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [STAT_W-1:0]        status;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output read_value, output status, output count, input ready);
	modport sink (input valid, input read_value, input status, input count, output ready);
endinterface

>>> rtl/core/bdq_cell.sv
module bdq_cell import bdq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic [$clog2(DEPTH+1)-1:0] count,
	input  logic [$clog2(DEPTH+1)-1:0] sel_idx,
	input  logic [DATA_W-1:0]        push_data,
	input  logic [DATA_W-1:0]        left_data,
	input  logic [DATA_W-1:0]        right_data,
	output logic [DATA_W-1:0]        data,
	output logic [DATA_W-1:0]        sel_data
);

	localparam int CW = $clog2(DEPTH+1);

	logic [DATA_W-1:0] data_q;

	// Front-aligned row: cell IDX holds entry IDX counted from the front.
	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
		end else if (ctrl.push_back && count == CW'(IDX)) begin
			data_q <= push_data;
		end
	end

	assign data     = data_q;
	assign sel_data = (sel_idx == CW'(IDX)) ? data_q : '0;

endmodule

>>> rtl/core/bounded_deque_unit.sv
// Result: registered at the request transfer and presented in the cycle after it.
// Throughput: one request per cycle unless stalled; cell row and count update on transfer.
// A stalled result is held in the output register; a new request is taken when it leaves.
// Reset clears the entry count and the output valid; cell contents stay undefined,
// with no clearing pass.
module bounded_deque_unit import bdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(DEPTH+1);

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_d;
	logic [CW-1:0]         sel_idx;
	cell_ctrl_t            ctrl;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  rd_en;
	st_t                   st_d;
	op_t                   op;
	logic [DATA_W-1:0]     rd_or;
	logic [DATA_W-1:0]     cell_data [DEPTH];
	logic [DATA_W-1:0]     cell_sel [DEPTH];
	logic [CW+COUNT_W-1:0] cnt_wide;

	logic                  rsp_valid_q;
	logic [DATA_W-1:0]     rsp_value_q;
	st_t                   rsp_status_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign op        = op_t'(req.opcode);

	always_comb begin
		ctrl    = '0;
		sel_idx = '0;
		st_d    = ST_OK;
		rd_en   = 1'b0;
		cnt_d   = cnt_q;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl.push_front = accept;
					cnt_d = cnt_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					ctrl.push_back = accept;
					cnt_d = cnt_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					ctrl.pop_front = accept;
					rd_en = 1'b1;
					cnt_d = cnt_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					sel_idx = cnt_q - CW'(1);
					rd_en = 1'b1;
					cnt_d = cnt_q - CW'(1);
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_PEEK_BACK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					sel_idx = cnt_q - CW'(1);
					rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = req.value;
		end else begin : g_mid
			assign left_data = cell_data[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_data = '0;
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		bdq_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (cnt_q),
			.sel_idx    (sel_idx),
			.push_data  (req.value),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i]),
			.sel_data   (cell_sel[i])
		);
	end

	// Only the selected cell drives non-zero.
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_sel[i];
		end
	end

	assign cnt_wide = (CW+COUNT_W)'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
			end
			if (req.ready) begin
				rsp_valid_q <= req.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q  <= rd_en ? rd_or : '0;
			rsp_status_q <= st_d;
			rsp_count_q  <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.count      = rsp_count_q;

	`BDQ_ASSERT_NEVER(a_count_bound, clk, arst_n, cnt_q > CW'(DEPTH), "count beyond depth")
	`BDQ_ASSERT(a_full_drop, clk, arst_n, accept && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) |=> rsp_status_q == ST_FULL && $stable(cnt_q), "push on full not dropped")
	`BDQ_ASSERT(a_pop_dec, clk, arst_n, accept && !empty && (op == OP_POP_FRONT || op == OP_POP_BACK) |=> cnt_q == $past(cnt_q) - CW'(1), "pop did not decrement count")

endmodule
